// File: design/lers_pkg.sv
// Package for the linear envelope ramp segment block.
// Holds payload structs, register indices, status codes and Q1.23 constants.
// No dependencies.
package lers_pkg;

  localparam int LEVEL_W = 24;
  localparam int STEP_W = 23;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_GATE_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_TRIGGER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_UP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DOWN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_BORDER = 3'd5;

  localparam logic [1:0] STATUS_RUNNING = 2'd0;
  localparam logic [1:0] STATUS_BORDER = 2'd1;
  localparam logic [1:0] STATUS_GATE = 2'd2;
  localparam logic [1:0] STATUS_RETRIGGER = 2'd3;

  localparam logic [1:0] GATE_OFF = 2'd0;

  localparam logic signed [LEVEL_W-1:0] HALF_Q23 = 24'sh400000;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 24'sh7FFFFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] gate_sample;
    logic signed [LEVEL_W-1:0] trigger_sample;
  } in_t;

  typedef struct packed {
    logic                      sample_valid;
    logic signed [LEVEL_W-1:0] level_out;
    logic [1:0]                status;
  } out_t;

  typedef struct packed {
    logic [1:0]                gate_mode;
    logic                      check_trigger;
    logic                      step_up;
    logic                      step_dn;
    logic [STEP_W-1:0]         ramp_delta;
    logic signed [LEVEL_W-1:0] ramp_target;
  } cfg_t;

endpackage

// File: design/lers_cfg_regs.sv
// Configuration register file of the envelope ramp segment.
// Depends on lers_pkg for register indices and the cfg_t struct.
module lers_cfg_regs import lers_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GATE_MODE:     cfg_nxt.gate_mode = cfg_wdata[1:0];
        CFG_CHECK_TRIGGER: cfg_nxt.check_trigger = cfg_wdata[0];
        CFG_STEP_UP:       cfg_nxt.step_up = cfg_wdata[0];
        CFG_STEP_DOWN:     cfg_nxt.step_dn = cfg_wdata[0];
        CFG_LEVEL_STEP:    cfg_nxt.ramp_delta = cfg_wdata[STEP_W-1:0];
        CFG_LEVEL_BORDER:  cfg_nxt.ramp_target = $signed(cfg_wdata[LEVEL_W-1:0]);
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/lers_step_logic.sv
// One tick of the ramp: gate check, trigger edge, saturating step, border test.
// Purely combinational; depends on lers_pkg.
module lers_step_logic import lers_pkg::*; (
  input  cfg_t                      cfg,
  input  in_t                       item,
  input  logic signed [LEVEL_W-1:0] env_level,
  input  logic signed [LEVEL_W-1:0] prev_trigger,
  output out_t                      res,
  output logic signed [LEVEL_W-1:0] env_level_nxt,
  output logic signed [LEVEL_W-1:0] prev_trigger_nxt
);

  localparam int SUM_W = LEVEL_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(LEVEL_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(LEVEL_MIN);

  logic                      gate_stop;
  logic                      rise;
  logic signed [SUM_W-1:0]   step_ext;
  logic signed [SUM_W-1:0]   sum;
  logic signed [LEVEL_W-1:0] sat;
  logic                      hit;

  always_comb begin
    if (cfg.gate_mode == GATE_OFF) begin
      gate_stop = 1'b0;
    end else if (cfg.gate_mode[1]) begin
      gate_stop = item.gate_sample >= HALF_Q23;
    end else begin
      gate_stop = item.gate_sample < HALF_Q23;
    end

    rise = cfg.check_trigger && (prev_trigger < item.trigger_sample);

    step_ext = $signed({{(SUM_W-STEP_W){1'b0}}, cfg.ramp_delta});
    sum = SUM_W'(env_level);
    if (cfg.step_up) begin
      sum = sum + step_ext;
    end
    if (cfg.step_dn) begin
      sum = sum - step_ext;
    end
    if (sum > SUM_MAX) begin
      sat = LEVEL_MAX;
    end else if (sum < SUM_MIN) begin
      sat = LEVEL_MIN;
    end else begin
      sat = sum[LEVEL_W-1:0];
    end

    // with both directions on, the upward test is strict
    hit = 1'b0;
    if (cfg.step_up) begin
      if (cfg.step_dn ? (sat > cfg.ramp_target) : (sat >= cfg.ramp_target)) begin
        hit = 1'b1;
      end
    end
    if (cfg.step_dn && (sat <= cfg.ramp_target)) begin
      hit = 1'b1;
    end

    env_level_nxt = env_level;
    prev_trigger_nxt = prev_trigger;
    res = '0;
    if (gate_stop) begin
      res.status = STATUS_GATE;
    end else begin
      if (cfg.check_trigger) begin
        prev_trigger_nxt = item.trigger_sample;
      end
      if (rise) begin
        res.status = STATUS_RETRIGGER;
      end else begin
        env_level_nxt = hit ? cfg.ramp_target : sat;
        res.sample_valid = 1'b1;
        res.level_out = env_level_nxt;
        res.status = hit ? STATUS_BORDER : STATUS_RUNNING;
      end
    end
  end

endmodule

// File: design/linear_envelope_ramp_segment_core.sv
// Top level of the linear envelope ramp segment: input register, step logic,
// result register. Depends on lers_pkg, lers_cfg_regs and lers_step_logic.
//
//   port group  | direction | handshake            | payload
//   in_*        | input     | in_valid / in_ready  | in_data (in_t)
//   out_*       | output    | out_valid / out_ready| out_data (out_t)
//   cfg_*       | input     | cfg_we               | cfg_index, cfg_wdata
//
// Input register, then result register; one item per cycle when not stalled.
// The envelope level and last trigger update as an item moves from the input
// register into the result register, so the single add/compare path sets it.
// Active-low synchronous reset clears valid flags, state and config registers.
// A stalled result holds; the input register still fills behind it.
module linear_envelope_ramp_segment_core import lers_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  logic                      s1_valid_r;
  in_t                       s1_data_r;
  logic                      out_valid_r;
  out_t                      out_data_r;
  logic signed [LEVEL_W-1:0] env_level_r;
  logic signed [LEVEL_W-1:0] prev_trigger_r;

  out_t                      res;
  logic signed [LEVEL_W-1:0] env_level_nxt;
  logic signed [LEVEL_W-1:0] prev_trigger_nxt;
  logic                      advance;
  logic                      in_fire;

  lers_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lers_step_logic u_step (
    .cfg              (cfg),
    .item             (s1_data_r),
    .env_level        (env_level_r),
    .prev_trigger     (prev_trigger_r),
    .res              (res),
    .env_level_nxt    (env_level_nxt),
    .prev_trigger_nxt (prev_trigger_nxt)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      env_level_r    <= '0;
      prev_trigger_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r    <= 1'b1;
        env_level_r    <= env_level_nxt;
        prev_trigger_r <= prev_trigger_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an item that advances from stage one always reaches the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item did not reach result register");

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while pipeline had room");

  a_no_sample_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.sample_valid) |-> (out_data.level_out == '0))
    else $error("level nonzero on a transaction without sample");

  a_status_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sample_valid ==
                   ((out_data.status == STATUS_RUNNING) ||
                    (out_data.status == STATUS_BORDER))))
    else $error("status and sample_valid disagree");

  a_state_held_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(env_level_r) && $stable(prev_trigger_r)))
    else $error("ramp state changed with no item processed");

endmodule
